// File: hw/rtl/mi3_pkg.sv
package mi3_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int N_ELEM    = 9;

	// Full-width intermediate formats.
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int COF_BITS  = PROD_BITS + 1;
	localparam int LO_BITS   = WORD_BITS + 1;
	localparam int PPH_BITS  = 2 * WORD_BITS;
	localparam int PPL_BITS  = 2 * WORD_BITS + 2;
	localparam int DET_BITS  = 3 * WORD_BITS + 3;
	localparam int NUM_BITS  = COF_BITS + 2 * FRAC_BITS;
	localparam int CMP_BITS  = (DET_BITS + WORD_BITS > NUM_BITS) ?
		DET_BITS + WORD_BITS : NUM_BITS;

	// One quotient bit per divider stage.
	localparam int DIV_STAGES = WORD_BITS;
	// Cofactor (2) + determinant (3) + sign prep (1) + range check (1)
	// + divider + output register (1).
	localparam int LAT = 8 + DIV_STAGES;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [COF_BITS-1:0]  cof_t;
	typedef logic signed [DET_BITS-1:0]  det_t;

	// Cofactor k = A[PA[k]]*A[PB[k]] - A[PC[k]]*A[PD[k]], row-major indexes.
	localparam int PA [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int PB [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int PC [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int PD [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

// File: hw/rtl/mi3_mat_if.sv
interface mi3_mat_if import mi3_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t a_r1c1;
	word_t a_r1c2;
	word_t a_r1c3;
	word_t a_r2c1;
	word_t a_r2c2;
	word_t a_r2c3;
	word_t a_r3c1;
	word_t a_r3c2;
	word_t a_r3c3;

	modport source (output valid, a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3,
		a_r3c1, a_r3c2, a_r3c3, input ready);
	modport sink (input valid, a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3,
		a_r3c1, a_r3c2, a_r3c3, output ready);
endinterface

interface mi3_inv_if import mi3_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t inv_r1c1;
	word_t inv_r1c2;
	word_t inv_r1c3;
	word_t inv_r2c1;
	word_t inv_r2c2;
	word_t inv_r2c3;
	word_t inv_r3c1;
	word_t inv_r3c2;
	word_t inv_r3c3;
	logic  singular;
	logic  overflow;

	modport source (output valid, inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, inv_r2c2,
		inv_r2c3, inv_r3c1, inv_r3c2, inv_r3c3, singular, overflow, input ready);
	modport sink (input valid, inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, inv_r2c2,
		inv_r2c3, inv_r3c1, inv_r3c2, inv_r3c3, singular, overflow, output ready);
endinterface

// File: hw/rtl/mi3_cofactor.sv
module mi3_cofactor import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t a [N_ELEM],
	output word_t row_s2 [3],
	output cof_t  cof_s2 [N_ELEM]
);

	prod_t pp_s1 [N_ELEM];
	prod_t pm_s1 [N_ELEM];
	word_t row_s1 [3];

	// Stage 1: the eighteen two-element products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				pp_s1[k] <= a[PA[k]] * a[PB[k]];
				pm_s1[k] <= a[PC[k]] * a[PD[k]];
			end
			for (int c = 0; c < 3; c++) begin
				row_s1[c] <= a[c];
			end
		end
	end

	// Stage 2: cofactor differences at full width.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				cof_s2[k] <= COF_BITS'(pp_s1[k]) - COF_BITS'(pm_s1[k]);
			end
			row_s2 <= row_s1;
		end
	end

endmodule

// File: hw/rtl/mi3_det.sv
module mi3_det import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t row_s2 [3],
	input  cof_t  cof_s2 [N_ELEM],
	output det_t  det_s5,
	output cof_t  cof_s5 [N_ELEM]
);

	// First-row expansion uses the adjugate entries 0, 3 and 6.
	localparam int CI [3] = '{0, 3, 6};

	logic signed [PPH_BITS-1:0] pph_s3 [3];
	logic signed [PPL_BITS-1:0] ppl_s3 [3];
	det_t term_s4 [3];
	cof_t cof_s3 [N_ELEM];
	cof_t cof_s4 [N_ELEM];

	// Stage 3: each row element times the high and low parts of its cofactor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pph_s3[c] <= row_s2[c] * $signed(cof_s2[CI[c]][COF_BITS-1:LO_BITS]);
				ppl_s3[c] <= row_s2[c] * $signed({1'b0, cof_s2[CI[c]][LO_BITS-1:0]});
			end
			cof_s3 <= cof_s2;
		end
	end

	// Stage 4: recombine the partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				term_s4[c] <= (DET_BITS'(pph_s3[c]) <<< LO_BITS) + DET_BITS'(ppl_s3[c]);
			end
			cof_s4 <= cof_s3;
		end
	end

	// Stage 5: determinant.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

endmodule

// File: hw/rtl/mi3_div.sv
module mi3_div import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  det_t  det_s5,
	input  cof_t  cof_s5 [N_ELEM],
	output word_t res_q [N_ELEM],
	output logic  sing_q,
	output logic  ovf_q
);

	logic [NUM_BITS-1:0] anum_s6 [N_ELEM];
	logic [DET_BITS-1:0] adet_s6;
	logic                neg_s6 [N_ELEM];
	logic                sing_s6;

	logic [NUM_BITS-1:0]  rem_s  [DIV_STAGES+1][N_ELEM];
	logic [WORD_BITS-1:0] quo_s  [DIV_STAGES+1][N_ELEM];
	logic                 neg_s  [DIV_STAGES+1][N_ELEM];
	logic                 big_s  [DIV_STAGES+1][N_ELEM];
	logic [DET_BITS-1:0]  adet_s [DIV_STAGES+1];
	logic                 sing_s [DIV_STAGES+1];

	word_t                res_d [N_ELEM];
	logic                 ovf_d [N_ELEM];
	logic                 ovf_any;

	// Sign split: numerator is the cofactor scaled by two fraction widths.
	always_ff @(posedge clk) begin
		logic signed [NUM_BITS-1:0] num;
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				num = NUM_BITS'(cof_s5[k]) <<< (2 * FRAC_BITS);
				anum_s6[k] <= num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
				neg_s6[k]  <= cof_s5[k][COF_BITS-1] ^ det_s5[DET_BITS-1];
			end
			adet_s6 <= det_s5[DET_BITS-1] ? DET_BITS'(-det_s5) : DET_BITS'(det_s5);
			sing_s6 <= (det_s5 == '0);
		end
	end

	// A quotient of 2^WORD_BITS or more always saturates; the divider then
	// only needs WORD_BITS quotient bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ELEM; k++) begin
				big_s[0][k] <= CMP_BITS'(anum_s6[k]) >=
					(CMP_BITS'(adet_s6) << WORD_BITS);
				rem_s[0][k] <= anum_s6[k];
				quo_s[0][k] <= '0;
				neg_s[0][k] <= neg_s6[k];
			end
			adet_s[0] <= adet_s6;
			sing_s[0] <= sing_s6;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		localparam int B = DIV_STAGES - 1 - j;
		always_ff @(posedge clk) begin
			logic [CMP_BITS-1:0] sh;
			if (en) begin
				sh = CMP_BITS'(adet_s[j]) << B;
				for (int k = 0; k < N_ELEM; k++) begin
					if (CMP_BITS'(rem_s[j][k]) >= sh) begin
						rem_s[j+1][k] <= NUM_BITS'(CMP_BITS'(rem_s[j][k]) - sh);
						quo_s[j+1][k] <= quo_s[j][k] | (WORD_BITS'(1) << B);
					end else begin
						rem_s[j+1][k] <= rem_s[j][k];
						quo_s[j+1][k] <= quo_s[j][k];
					end
					neg_s[j+1][k] <= neg_s[j][k];
					big_s[j+1][k] <= big_s[j][k];
				end
				adet_s[j+1] <= adet_s[j];
				sing_s[j+1] <= sing_s[j];
			end
		end
	end

	// Saturate, restore the sign and clear everything for a singular matrix.
	always_comb begin
		logic [WORD_BITS-1:0] lim;
		logic [WORD_BITS-1:0] mag;
		ovf_any = 1'b0;
		for (int k = 0; k < N_ELEM; k++) begin
			lim = (WORD_BITS'(1) << (WORD_BITS - 1)) -
				WORD_BITS'(!neg_s[DIV_STAGES][k]);
			ovf_d[k] = big_s[DIV_STAGES][k] || (quo_s[DIV_STAGES][k] > lim);
			mag = ovf_d[k] ? lim : quo_s[DIV_STAGES][k];
			res_d[k] = neg_s[DIV_STAGES][k] ? word_t'(-mag) : word_t'(mag);
			if (sing_s[DIV_STAGES]) begin
				res_d[k] = '0;
				ovf_d[k] = 1'b0;
			end
			ovf_any = ovf_any | ovf_d[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res_d;
			sing_q <= sing_s[DIV_STAGES];
			ovf_q  <= ovf_any;
		end
	end

endmodule

// File: hw/rtl/matrix_inverse_3x3.sv
// Channel | Role   | Word
// mat     | sink   | nine signed Q16.16 matrix elements, row-major
// inv     | source | nine signed Q16.16 inverse elements, singular, overflow
//
// The pipeline holds two cofactor stages, three determinant stages, sign
// preparation, a range check, one restoring divider stage per quotient bit
// and the output register.
// One matrix is accepted every cycle unless the output stalls; the divider stages set the latency.
// arst_n clears only the valid bits; the data path carries no reset.
// The whole pipeline advances whenever the output is empty or being taken,
// so a stall freezes every stage and nothing is dropped or repeated.
module matrix_inverse_3x3 import mi3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mi3_mat_if.sink   mat,
	mi3_inv_if.source inv
);

	// One valid bit per pipeline stage; the last one is the output register.
	logic [LAT-1:0] vld_q;
	logic           en;

	word_t a      [N_ELEM];
	word_t row_s2 [3];
	cof_t  cof_s2 [N_ELEM];
	cof_t  cof_s5 [N_ELEM];
	det_t  det_s5;
	word_t res_q  [N_ELEM];
	logic  sing_q;
	logic  ovf_q;

	// Advance when the output register is free or its word leaves this cycle.
	assign en        = !vld_q[LAT-1] || inv.ready;
	assign mat.ready = en;

	assign a[0] = mat.a_r1c1;
	assign a[1] = mat.a_r1c2;
	assign a[2] = mat.a_r1c3;
	assign a[3] = mat.a_r2c1;
	assign a[4] = mat.a_r2c2;
	assign a[5] = mat.a_r2c3;
	assign a[6] = mat.a_r3c1;
	assign a[7] = mat.a_r3c2;
	assign a[8] = mat.a_r3c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], mat.valid};
		end
	end

	mi3_cofactor u_cof (
		.clk    (clk),
		.en     (en),
		.a      (a),
		.row_s2 (row_s2),
		.cof_s2 (cof_s2)
	);

	mi3_det u_det (
		.clk    (clk),
		.en     (en),
		.row_s2 (row_s2),
		.cof_s2 (cof_s2),
		.det_s5 (det_s5),
		.cof_s5 (cof_s5)
	);

	mi3_div u_div (
		.clk    (clk),
		.en     (en),
		.det_s5 (det_s5),
		.cof_s5 (cof_s5),
		.res_q  (res_q),
		.sing_q (sing_q),
		.ovf_q  (ovf_q)
	);

	assign inv.valid    = vld_q[LAT-1];
	assign inv.inv_r1c1 = res_q[0];
	assign inv.inv_r1c2 = res_q[1];
	assign inv.inv_r1c3 = res_q[2];
	assign inv.inv_r2c1 = res_q[3];
	assign inv.inv_r2c2 = res_q[4];
	assign inv.inv_r2c3 = res_q[5];
	assign inv.inv_r3c1 = res_q[6];
	assign inv.inv_r3c2 = res_q[7];
	assign inv.inv_r3c3 = res_q[8];
	assign inv.singular = sing_q;
	assign inv.overflow = ovf_q;

	// An accepted matrix occupies the first stage in the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> vld_q[0])
		else $error("accepted word did not enter the pipeline");

	// A stall freezes the occupancy of every stage.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

	// A singular result carries zero elements and no overflow.
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.singular |-> !inv.overflow && inv.inv_r1c1 == '0 &&
			inv.inv_r2c2 == '0 && inv.inv_r3c3 == '0)
		else $error("singular result is not cleared");

endmodule

// File: tb/sv/tb.sv
module tb;
	import mi3_pkg::*;

	// A matrix or an inverse as nine elements, index 0 is r1c1, row-major.
	typedef logic [N_ELEM-1:0][WORD_BITS-1:0] elems_t;

	// One expected inverse word on the inv channel.
	typedef struct packed {
		elems_t el;
		logic   singular;
		logic   overflow;
	} inv_word_t;

	// One row of the directed table. When typed is set, the expected word is
	// written out in the row itself; otherwise the predictor supplies it.
	typedef struct {
		elems_t    m;
		bit        typed;
		inv_word_t want;
	} dir_row_t;

	localparam logic [WORD_BITS-1:0] ONE  = 32'h0001_0000;
	localparam logic [WORD_BITS-1:0] MONE = 32'hFFFF_0000;
	localparam logic [WORD_BITS-1:0] WMAX = 32'h7FFF_FFFF;
	localparam logic [WORD_BITS-1:0] WMIN = 32'h8000_0000;
	localparam int   N_RANDOM = 400;
	localparam int   LIMIT    = 400000;

	logic clk;
	logic arst_n;

	mi3_mat_if mat ();
	mi3_inv_if inv ();

	matrix_inverse_3x3 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat.sink),
		.inv    (inv.source)
	);

	inv_word_t pending_inv[$];
	int        n_mismatch;
	int        cycles;
	int        idle_pct;
	int        stall_pct;
	dir_row_t  dir_rows[$];

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The inverse of one matrix, worked out at a width where nothing can wrap:
	// the determinant needs about 96 bits and the shifted cofactor about 97.
	function automatic inv_word_t invert(elems_t m);
		logic signed [255:0] a[N_ELEM];
		logic signed [255:0] det;
		logic signed [255:0] cof;
		logic signed [255:0] quo;
		int ia[N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
		int ib[N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
		int ic[N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
		int id[N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
		inv_word_t r;
		for (int k = 0; k < N_ELEM; k++)
			a[k] = word_t'(m[k]);
		det = a[0] * a[4] * a[8] + a[3] * a[2] * a[7] + a[6] * a[1] * a[5]
			- a[2] * a[4] * a[6] - a[0] * a[5] * a[7] - a[1] * a[3] * a[8];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int k = 0; k < N_ELEM; k++) begin
			cof = a[ia[k]] * a[ib[k]] - a[ic[k]] * a[id[k]];
			// Signed division here truncates toward zero, as the block does.
			quo = (cof <<< (2 * FRAC_BITS)) / det;
			if (quo > 256'sh7FFF_FFFF) begin
				quo = 256'sh7FFF_FFFF;
				r.overflow = 1'b1;
			end else if (quo < -256'sh8000_0000) begin
				quo = -256'sh8000_0000;
				r.overflow = 1'b1;
			end
			r.el[k] = quo[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic elems_t diag(logic [WORD_BITS-1:0] d);
		elems_t m;
		m = '0;
		m[0] = d;
		m[4] = d;
		m[8] = d;
		return m;
	endfunction

	function automatic elems_t fill(logic [WORD_BITS-1:0] v);
		elems_t m;
		for (int k = 0; k < N_ELEM; k++)
			m[k] = v;
		return m;
	endfunction

	function automatic inv_word_t typed_inv(elems_t el, logic sing, logic ovf);
		inv_word_t r;
		r.el = el;
		r.singular = sing;
		r.overflow = ovf;
		return r;
	endfunction

	// Random element with a chosen magnitude class: full range, small values
	// around a few units, one of the extremes, or within four LSBs of zero.
	function automatic logic [WORD_BITS-1:0] rand_elem();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 20)
			return $urandom();
		else if (sel < 85)
			return WORD_BITS'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		else if (sel < 92)
			return $urandom_range(0, 1) ? WMAX : WMIN;
		else
			return WORD_BITS'($signed($urandom_range(0, 8)) - 4);
	endfunction

	function automatic elems_t rand_mat();
		elems_t m;
		int shape;
		for (int k = 0; k < N_ELEM; k++)
			m[k] = rand_elem();
		shape = $urandom_range(0, 9);
		// A repeated row or column makes the matrix singular; a diagonal
		// matrix gives exact reciprocals.
		if (shape == 0) begin
			for (int j = 0; j < 3; j++)
				m[6 + j] = m[j];
		end else if (shape == 1) begin
			for (int i = 0; i < 3; i++)
				m[i * 3 + 2] = m[i * 3];
		end else if (shape == 2) begin
			for (int k = 0; k < N_ELEM; k++)
				if (k % 4 != 0)
					m[k] = '0;
		end
		return m;
	endfunction

	// Offers one word on the mat channel, with random idle cycles first, and
	// queues the expected inverse once the word has been taken.
	task automatic send_matrix(elems_t m, bit typed, inv_word_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			mat.valid = 1'b0;
			@(negedge clk);
		end
		mat.valid  = 1'b1;
		mat.a_r1c1 = m[0];
		mat.a_r1c2 = m[1];
		mat.a_r1c3 = m[2];
		mat.a_r2c1 = m[3];
		mat.a_r2c2 = m[4];
		mat.a_r2c3 = m[5];
		mat.a_r3c1 = m[6];
		mat.a_r3c2 = m[7];
		mat.a_r3c3 = m[8];
		do
			@(posedge clk);
		while (!mat.ready);
		pending_inv.push_back(typed ? want : invert(m));
		@(negedge clk);
	endtask

	task automatic drain();
		mat.valid = 1'b0;
		wait (pending_inv.size() == 0);
		@(negedge clk);
	endtask

	// The receiver decides its ready for each cycle at the falling edge.
	always @(negedge clk)
		inv.ready = ($urandom_range(0, 99) >= stall_pct);

	// Every word taken from the inv channel is checked against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		inv_word_t want;
		inv_word_t got;
		if (arst_n && inv.valid && inv.ready) begin
			got.el[0] = inv.inv_r1c1;
			got.el[1] = inv.inv_r1c2;
			got.el[2] = inv.inv_r1c3;
			got.el[3] = inv.inv_r2c1;
			got.el[4] = inv.inv_r2c2;
			got.el[5] = inv.inv_r2c3;
			got.el[6] = inv.inv_r3c1;
			got.el[7] = inv.inv_r3c2;
			got.el[8] = inv.inv_r3c3;
			got.singular = inv.singular;
			got.overflow = inv.overflow;
			if (pending_inv.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("inverse word with nothing expected: %h", got);
			end else begin
				want = pending_inv.pop_front();
				for (int k = 0; k < N_ELEM; k++)
					if (got.el[k] !== want.el[k]) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("element %0d: expected %h, got %h",
								k, want.el[k], got.el[k]);
					end
				if (got.singular !== want.singular) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("singular: expected %b, got %b",
							want.singular, got.singular);
				end
				if (got.overflow !== want.overflow) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("overflow: expected %b, got %b",
							want.overflow, got.overflow);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[matrix_inverse_3x3] ERROR");
			$finish;
		end
	end

	initial begin
		elems_t tmp;
		inv_word_t none;
		n_mismatch = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		none = '0;
		arst_n = 1'b0;
		mat.valid = 1'b0;
		mat.a_r1c1 = '0;
		mat.a_r1c2 = '0;
		mat.a_r1c3 = '0;
		mat.a_r2c1 = '0;
		mat.a_r2c2 = '0;
		mat.a_r2c3 = '0;
		mat.a_r3c1 = '0;
		mat.a_r3c2 = '0;
		mat.a_r3c3 = '0;

		// Directed table. The identity and its negative invert to themselves,
		// all-equal matrices are singular, and a diagonal of one least
		// significant bit has a reciprocal far past the range, so it clamps.
		dir_rows.push_back('{diag(ONE), 1, typed_inv(diag(ONE), 0, 0)});
		dir_rows.push_back('{diag(MONE), 1, typed_inv(diag(MONE), 0, 0)});
		dir_rows.push_back('{fill('0), 1, typed_inv('0, 1, 0)});
		dir_rows.push_back('{fill(WMAX), 1, typed_inv('0, 1, 0)});
		dir_rows.push_back('{fill(WMIN), 1, typed_inv('0, 1, 0)});
		dir_rows.push_back('{fill(ONE), 1, typed_inv('0, 1, 0)});
		dir_rows.push_back('{diag(32'h1), 1, typed_inv(diag(WMAX), 0, 1)});
		dir_rows.push_back('{diag(32'hFFFF_FFFF), 1, typed_inv(diag(WMIN), 0, 1)});
		dir_rows.push_back('{diag(32'h0002_0000), 1, typed_inv(diag(32'h0000_8000), 0, 0)});
		dir_rows.push_back('{diag(WMAX), 0, none});
		dir_rows.push_back('{diag(WMIN), 0, none});
		tmp = diag(ONE);
		tmp[1] = WMAX;
		tmp[5] = WMIN;
		dir_rows.push_back('{tmp, 0, none});
		tmp = diag(32'h0003_0000);
		tmp[6] = 32'hFFFE_8000;
		tmp[2] = 32'h0000_0001;
		dir_rows.push_back('{tmp, 0, none});
		// A permutation matrix: rows swapped, determinant of minus one.
		tmp = '0;
		tmp[1] = ONE;
		tmp[3] = ONE;
		tmp[8] = ONE;
		dir_rows.push_back('{tmp, 0, none});
		tmp = fill(WMIN);
		tmp[0] = WMAX;
		tmp[4] = WMAX;
		tmp[8] = WMAX;
		dir_rows.push_back('{tmp, 0, none});
		tmp = '{32'h0001_8000, 32'hFFFF_C000, 32'h0000_4000, 32'h0002_0000,
			32'h0000_0000, 32'hFFFE_0000, 32'h0000_1000, 32'h0005_0000, 32'h0000_0003};
		dir_rows.push_back('{tmp, 0, none});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_matrix(dir_rows[i].m, dir_rows[i].typed, dir_rows[i].want);
		// Hold the sender off until the pipeline has emptied.
		drain();

		// Random part in four phases of idling: none, sender idle, receiver
		// stalling, then both at a light rate.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 8 : 0;
			stall_pct = (ph == 2) ? 52 : (ph == 3) ? 8 : 0;
			for (int n = 0; n < N_RANDOM / 4; n++)
				send_matrix(rand_mat(), 0, none);
		end
		mat.valid = 1'b0;
		stall_pct = 30;
		wait (pending_inv.size() == 0);
		repeat (LAT + 10) @(posedge clk);

		if (n_mismatch == 0)
			$display("[matrix_inverse_3x3] OK");
		else
			$display("[matrix_inverse_3x3] ERROR");
		$finish;
	end
endmodule

// File: matrix_inverse_3x3.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_mat_if.sv
hw/rtl/mi3_cofactor.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix_inverse_3x3.sv
tb/sv/tb.sv
